>>> sv/dbivt_pkg.sv
// Shared types and constants for the deadband integral voltage tracker.
`default_nettype none

package dbivt_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned DUTY_BITS_DEF   = 8;

  localparam int unsigned MV_BITS      = 13;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [MV_BITS-1:0] FULL_MV   = 13'd4954;
  localparam logic [MV_BITS-1:0] TOL_RESET = 13'd20;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SET_POINT     = 2'd0,
    REG_USE_FEEDBACK  = 2'd1,
    REG_EXTERNAL_MODE = 2'd2,
    REG_TOLERANCE     = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAS,
    ST_EXT,
    ST_EVAL,
    ST_ADJ,
    ST_OUT
  } state_e;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_STEP    = 1'b1
  } div_op_e;

  typedef struct packed {
    logic               use_feedback;
    logic               external_mode;
    logic [MV_BITS-1:0] tolerance_mv;
    logic               sp_load;
    logic [MV_BITS-1:0] sp_value;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/dbivt_div.sv
// Shared constant divider: one registered multiplication by a scaled reciprocal per request.
`default_nettype none

module dbivt_div #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned DUTY_BITS   = 8,
  parameter int unsigned OPD_BITS    = 13,
  parameter int unsigned QUO_BITS    = 13
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire dbivt_pkg::div_op_e    op_i,
  input  wire logic [OPD_BITS-1:0]   opd_i,
  output logic                       done_o,
  output logic [QUO_BITS-1:0]        quo_o
);

  import dbivt_pkg::*;

  // floor(x * n / d) equals (x * ceil(2^s * n / d)) >> s while x * (d - 1) < 2^s
  localparam longint unsigned FULL_SCALE  = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam int unsigned     CONV_SHIFT  = 2 * SAMPLE_BITS;
  localparam longint unsigned CONV_K      =
    (((64'd1 << CONV_SHIFT) * 64'(FULL_MV)) + FULL_SCALE - 64'd1) / FULL_SCALE;
  localparam int unsigned     STEP_SHIFT  = 2 * MV_BITS;
  localparam longint unsigned STEP_K      =
    ((64'd1 << (STEP_SHIFT + DUTY_BITS)) + 64'(FULL_MV) - 64'd1) / 64'(FULL_MV);
  localparam int unsigned     CONV_K_BITS = $clog2(CONV_K + 64'd1);
  localparam int unsigned     STEP_K_BITS = $clog2(STEP_K + 64'd1);
  localparam int unsigned     K_BITS      =
    (CONV_K_BITS > STEP_K_BITS) ? CONV_K_BITS : STEP_K_BITS;
  localparam int unsigned     PROD_BITS   = OPD_BITS + K_BITS;

  logic [K_BITS-1:0]    k_sel;
  logic [PROD_BITS-1:0] prod_q, prod_d;
  div_op_e              op_q, op_d;
  logic                 done_q, done_d;

  assign k_sel = (op_i == OP_STEP) ? K_BITS'(STEP_K) : K_BITS'(CONV_K);

  always_comb begin
    prod_d = prod_q;
    op_d   = op_q;
    done_d = start_i;
    if (start_i) begin
      prod_d = PROD_BITS'(opd_i) * PROD_BITS'(k_sel);
      op_d   = op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    op_q   <= op_d;
  end

  assign done_o = done_q;
  assign quo_o  = (op_q == OP_STEP) ? QUO_BITS'(prod_q >> STEP_SHIFT)
                                    : QUO_BITS'(prod_q >> CONV_SHIFT);

endmodule

`default_nettype wire

>>> sv/dbivt_seq.sv
// Step sequencer: conversion, set-point tracking, deadband check and duty update.
`default_nettype none

module dbivt_seq #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned DUTY_BITS   = 8,
  parameter int unsigned OPD_BITS    = 13,
  parameter int unsigned QUO_BITS    = 13
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dbivt_pkg::cfg_t                  cfg_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]           feedback_sample_i,
  input  wire logic [SAMPLE_BITS-1:0]           external_sample_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [DUTY_BITS-1:0]                  duty_cycle_o,
  output logic [dbivt_pkg::MV_BITS-1:0]         measured_mv_o,
  output logic [dbivt_pkg::MV_BITS-1:0]         target_mv_o,
  output logic                                  drive_written_o,
  output logic                                  div_start_o,
  output dbivt_pkg::div_op_e                    div_op_o,
  output logic [OPD_BITS-1:0]                   div_opd_o,
  input  wire logic                             div_done_i,
  input  wire logic [QUO_BITS-1:0]              div_quo_i
);

  import dbivt_pkg::*;

  state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] ext_q;
  logic [MV_BITS-1:0]     meas_q;
  logic [MV_BITS-1:0]     wsp_q, wsp_d;
  logic [DUTY_BITS-1:0]   duty_q, duty_d;
  logic                   neg_q;
  logic                   written_q, written_d;

  logic                   out_valid_q, out_valid_d;
  logic [DUTY_BITS-1:0]   out_duty_q;
  logic [MV_BITS-1:0]     out_meas_q;
  logic [MV_BITS-1:0]     out_target_q;
  logic                   out_written_q;

  logic                   neg;
  logic [MV_BITS-1:0]     mag;
  logic                   adjust;
  logic                   out_free;
  logic [MV_BITS-1:0]     conv_mv;
  logic [DUTY_BITS:0]     step;
  logic [DUTY_BITS:0]     sum;

  assign neg    = (wsp_q < meas_q);
  assign mag    = neg ? (meas_q - wsp_q) : (wsp_q - meas_q);
  assign adjust = cfg_i.use_feedback && (mag > cfg_i.tolerance_mv);

  assign out_free = !out_valid_q || out_ready_i;
  assign conv_mv  = div_quo_i[MV_BITS-1:0];
  assign step     = div_quo_i[DUTY_BITS:0];
  assign sum      = {1'b0, duty_q} + step;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MEAS;
      ST_MEAS: begin
        if (div_done_i) state_d = cfg_i.external_mode ? ST_EXT : ST_EVAL;
      end
      ST_EXT:  if (div_done_i) state_d = ST_EVAL;
      ST_EVAL: state_d = adjust ? ST_ADJ : ST_OUT;
      ST_ADJ:  if (div_done_i) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // divider requests and input handshake
  always_comb begin
    in_ready_o  = 1'b0;
    div_start_o = 1'b0;
    div_op_o    = OP_CONVERT;
    div_opd_o   = OPD_BITS'(feedback_sample_i);
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        div_start_o = in_valid_i;
      end
      ST_MEAS: begin
        div_start_o = div_done_i && cfg_i.external_mode;
        div_opd_o   = OPD_BITS'(ext_q);
      end
      ST_EVAL: begin
        div_start_o = adjust;
        div_op_o    = OP_STEP;
        div_opd_o   = OPD_BITS'(mag);
      end
      default: ;
    endcase
  end

  always_comb begin
    wsp_d     = wsp_q;
    duty_d    = duty_q;
    written_d = written_q;
    if (cfg_i.sp_load) wsp_d = cfg_i.sp_value;
    case (state_q)
      ST_EXT: begin
        if (div_done_i && (conv_mv <= FULL_MV)) wsp_d = conv_mv;
      end
      ST_EVAL: written_d = adjust;
      ST_ADJ: begin
        if (div_done_i) begin
          if (neg_q) begin
            duty_d = (step >= {1'b0, duty_q}) ? '0 : duty_q - step[DUTY_BITS-1:0];
          end else begin
            // saturate at full scale
            duty_d = sum[DUTY_BITS] ? {DUTY_BITS{1'b1}} : sum[DUTY_BITS-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if ((state_q == ST_OUT) && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wsp_q       <= '0;
      duty_q      <= '0;
      written_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wsp_q       <= wsp_d;
      duty_q      <= duty_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) ext_q <= external_sample_i;
    if ((state_q == ST_MEAS) && div_done_i) meas_q <= conv_mv;
    if (state_q == ST_EVAL) neg_q <= neg;
    if ((state_q == ST_OUT) && out_free) begin
      out_duty_q    <= duty_q;
      out_meas_q    <= meas_q;
      out_target_q  <= wsp_q;
      out_written_q <= written_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign duty_cycle_o    = out_duty_q;
  assign measured_mv_o   = out_meas_q;
  assign target_mv_o     = out_target_q;
  assign drive_written_o = out_written_q;

endmodule

`default_nettype wire

>>> sv/deadband_integral_voltage_tracker_top.sv
// Top level of the deadband integral voltage tracker: registers, sequencer, divider.
//
// Usage: one request on the input channel carries a feedback sample and an
// external set-point sample; one result comes back on the output channel with
// the duty cycle after the step, the measured and target voltages in mV and a
// flag that says whether the duty cycle was rewritten.
// Registers are written through the configuration channel (index, data); it is
// always ready. Writing the set point loads the working set point when in range.
// Every division is by a constant and runs on one shared unit that
// multiplies by a scaled reciprocal. A request has its feedback sample
// converted, its external set point converted in external mode, a deadband
// check and, with feedback on and outside the deadband, a duty step; then the
// output register is written and the block returns to idle to take the next.
// The input is not ready while a request is in work. Results sit in an output
// register, so the next request is taken while the previous result waits; a
// stalled receiver holds the block at its final step until the register frees.
// Reset clears the duty cycle and working set point, sets the tolerance to
// 20 mV, clears both mode bits and empties the output register.
`default_nettype none

module deadband_integral_voltage_tracker_top #(
  parameter int unsigned SAMPLE_BITS = dbivt_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DUTY_BITS   = dbivt_pkg::DUTY_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dbivt_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [dbivt_pkg::MV_BITS-1:0]       cfg_value_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]              feedback_sample_i,
  input  wire logic [SAMPLE_BITS-1:0]              external_sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [DUTY_BITS-1:0]                     duty_cycle_o,
  output logic [dbivt_pkg::MV_BITS-1:0]            measured_mv_o,
  output logic [dbivt_pkg::MV_BITS-1:0]            target_mv_o,
  output logic                                     drive_written_o
);

  import dbivt_pkg::*;

  localparam int unsigned OPD_BITS = (SAMPLE_BITS > MV_BITS) ? SAMPLE_BITS : MV_BITS;
  localparam int unsigned QUO_BITS = (DUTY_BITS + 1 > MV_BITS) ? DUTY_BITS + 1 : MV_BITS;

  logic               use_fb_q, use_fb_d;
  logic               ext_mode_q, ext_mode_d;
  logic [MV_BITS-1:0] tol_q, tol_d;
  logic               sp_load;
  cfg_t               cfg;

  logic                div_start;
  div_op_e             div_op;
  logic [OPD_BITS-1:0] div_opd;
  logic                div_done;
  logic [QUO_BITS-1:0] div_quo;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    use_fb_d   = use_fb_q;
    ext_mode_d = ext_mode_q;
    tol_d      = tol_q;
    sp_load    = 1'b0;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SET_POINT:     sp_load    = (cfg_value_i <= FULL_MV);
        REG_USE_FEEDBACK:  use_fb_d   = cfg_value_i[0];
        REG_EXTERNAL_MODE: ext_mode_d = cfg_value_i[0];
        REG_TOLERANCE:     tol_d      = cfg_value_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_fb_q   <= 1'b0;
      ext_mode_q <= 1'b0;
      tol_q      <= TOL_RESET;
    end else begin
      use_fb_q   <= use_fb_d;
      ext_mode_q <= ext_mode_d;
      tol_q      <= tol_d;
    end
  end

  always_comb begin
    cfg.use_feedback  = use_fb_q;
    cfg.external_mode = ext_mode_q;
    cfg.tolerance_mv  = tol_q;
    cfg.sp_load       = sp_load;
    cfg.sp_value      = cfg_value_i;
  end

  dbivt_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DUTY_BITS   (DUTY_BITS),
    .OPD_BITS    (OPD_BITS),
    .QUO_BITS    (QUO_BITS)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .feedback_sample_i (feedback_sample_i),
    .external_sample_i (external_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .duty_cycle_o      (duty_cycle_o),
    .measured_mv_o     (measured_mv_o),
    .target_mv_o       (target_mv_o),
    .drive_written_o   (drive_written_o),
    .div_start_o       (div_start),
    .div_op_o          (div_op),
    .div_opd_o         (div_opd),
    .div_done_i        (div_done),
    .div_quo_i         (div_quo)
  );

  dbivt_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DUTY_BITS   (DUTY_BITS),
    .OPD_BITS    (OPD_BITS),
    .QUO_BITS    (QUO_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .op_i    (div_op),
    .opd_i   (div_opd),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

`ifndef SYNTHESIS
  // an accepted request keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a request was accepted");

  // a new result only appears at the end of a request in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised while the sequencer was idle");
`endif

endmodule

`default_nettype wire
